FILE: hdl/breproj_pkg.sv
`timescale 1ns / 1ps

package breproj_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int LANES     = 4;
    localparam int LANE_W    = MAX_WIDTH / LANES;
    localparam int WIDTH_W   = 7;
    localparam int NUM_MASKS = 6;
    localparam int OUT_W     = NUM_MASKS * MAX_WIDTH;
    localparam int CNT_W     = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_WIDTH);

    typedef logic [MAX_WIDTH-1:0]             row_t;
    typedef logic [LANES-1:0][LANE_W-1:0]     lane_vec_t;

    // One result slot offered to the output stage
    typedef struct packed {
        logic valid;
        logic last;
    } job_ctrl_t;

endpackage

FILE: hdl/binary_run_edge_projection_top.sv
`timescale 1ns / 1ps

// Binary run edge projection. Each input transfer carries one image row
// (bit x is pixel x, 1 = foreground; s_tlast marks the final row). For each
// row the block returns its foreground mask, the left/right ends of every
// horizontal run, the top/bottom ends of every vertical run and the OR of
// those four masks. A row is reported once the row below it has arrived, so
// results lag by one row; the row marked last is reported straight after
// the row before it, with the image border as its bottom, and the block is
// then ready for a new image. The row width register (cfg_data, reset 64)
// masks the pixels of each row as it enters; 0 acts as 1 and anything above
// 64 acts as 64. The right border always ends a horizontal run. Rate: one
// row per clock while the output is not stalled; a final row that follows a
// pending row yields two results, and no new row is taken while both wait.
// The edge masks are built combinationally by four 16-pixel lanes from the
// job stage and registered at the output; a result enters the job stage when
// its completing row is accepted: the row below, or the row itself if last.
module binary_run_edge_projection_top
    import breproj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: row_width
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WIDTH_W-1:0]   cfg_data,
    // s_tdata[63:0] = row_pixels
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [MAX_WIDTH-1:0] s_tdata,
    input  logic                 s_tlast,
    // m_tdata from bit 0 up: row_foreground, left_edges, right_edges,
    // top_edges, bottom_edges, boundary (64 bits each)
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tlast
);

    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] width_eff;
    row_t               width_mask;
    row_t               row_in;

    // Row history: the row still owed a result and the row above it
    row_t               pending_reg;
    row_t               pending_next;
    row_t               above_pend_reg;
    row_t               above_pend_next;
    logic               have_pend_reg;
    logic               have_pend_next;

    // Job stage: up to two results queued as a sliding window of rows
    row_t               j_above_reg;
    row_t               j_above_next;
    row_t               j_cur_reg;
    row_t               j_cur_next;
    row_t               j_below_reg;
    row_t               j_below_next;
    logic [CNT_W-1:0]   j_cnt_reg;
    logic [CNT_W-1:0]   j_cnt_next;
    logic               j_tail_last_reg;
    logic               j_tail_last_next;

    logic               accept;
    logic               adv;
    logic               pop;
    job_ctrl_t          job;

    lane_vec_t          left_lanes;
    lane_vec_t          right_lanes;
    lane_vec_t          top_lanes;
    lane_vec_t          bottom_lanes;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    // Clamp the width into 1..MAX_WIDTH, then build the pixel mask
    always_comb
    begin
        width_eff = width_reg;
        if (width_reg == '0)
        begin
            width_eff = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            width_mask[i] = WIDTH_W'(i) < width_eff;
        end
    end

    assign row_in = s_tdata & width_mask;

    // Take a new row when the job stage is empty or its last job leaves now
    assign s_tready = (j_cnt_reg == CNT_W'(0)) || ((j_cnt_reg == CNT_W'(1)) && adv);
    assign accept   = s_tvalid && s_tready;
    assign pop      = (j_cnt_reg != CNT_W'(0)) && adv;

    assign job.valid = j_cnt_reg != CNT_W'(0);
    assign job.last  = (j_cnt_reg == CNT_W'(1)) && j_tail_last_reg;

    always_comb
    begin
        pending_next     = pending_reg;
        above_pend_next  = above_pend_reg;
        have_pend_next   = have_pend_reg;
        j_above_next     = j_above_reg;
        j_cur_next       = j_cur_reg;
        j_below_next     = j_below_reg;
        j_cnt_next       = j_cnt_reg;
        j_tail_last_next = j_tail_last_reg;

        // Slide the window: the second job sees the first row as its top
        if (pop)
        begin
            j_cnt_next   = j_cnt_reg - CNT_W'(1);
            j_above_next = j_cur_reg;
            j_cur_next   = j_below_reg;
            j_below_next = '0;
        end

        if (accept)
        begin
            if (have_pend_reg)
            begin
                j_above_next     = above_pend_reg;
                j_cur_next       = pending_reg;
                j_below_next     = row_in;
                j_cnt_next       = s_tlast ? CNT_W'(2) : CNT_W'(1);
                j_tail_last_next = s_tlast;
            end
            else if (s_tlast)
            begin
                j_above_next     = '0;
                j_cur_next       = row_in;
                j_below_next     = '0;
                j_cnt_next       = CNT_W'(1);
                j_tail_last_next = 1'b1;
            end

            // Close the image on the last row, otherwise hold the new row
            if (s_tlast)
            begin
                pending_next    = '0;
                above_pend_next = '0;
                have_pend_next  = 1'b0;
            end
            else
            begin
                above_pend_next = have_pend_reg ? pending_reg : '0;
                pending_next    = row_in;
                have_pend_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            above_pend_reg  <= '0;
            have_pend_reg   <= 1'b0;
            j_cnt_reg       <= '0;
            j_tail_last_reg <= 1'b0;
        end
        else
        begin
            pending_reg     <= pending_next;
            above_pend_reg  <= above_pend_next;
            have_pend_reg   <= have_pend_next;
            j_cnt_reg       <= j_cnt_next;
            j_tail_last_reg <= j_tail_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_above_reg <= j_above_next;
        j_cur_reg   <= j_cur_next;
        j_below_reg <= j_below_next;
    end

    // Edge lanes, each fed the boundary pixels of its neighbours
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic left_nb;
        logic right_nb;

        if (k == 0)
        begin : g_first
            assign left_nb = 1'b0;
        end
        else
        begin : g_inner_l
            assign left_nb = j_cur_reg[k*LANE_W-1];
        end

        if (k == LANES-1)
        begin : g_last
            assign right_nb = 1'b0;
        end
        else
        begin : g_inner_r
            assign right_nb = j_cur_reg[(k+1)*LANE_W];
        end

        breproj_lane u_lane (
            .cur          (j_cur_reg[k*LANE_W +: LANE_W]),
            .above        (j_above_reg[k*LANE_W +: LANE_W]),
            .below        (j_below_reg[k*LANE_W +: LANE_W]),
            .left_nb      (left_nb),
            .right_nb     (right_nb),
            .left_edges   (left_lanes[k]),
            .right_edges  (right_lanes[k]),
            .top_edges    (top_lanes[k]),
            .bottom_edges (bottom_lanes[k])
        );
    end

    breproj_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .cur          (j_cur_reg),
        .left_lanes   (left_lanes),
        .right_lanes  (right_lanes),
        .top_lanes    (top_lanes),
        .bottom_lanes (bottom_lanes),
        .adv          (adv),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

FILE: hdl/breproj_lane.sv
`timescale 1ns / 1ps

module breproj_lane
    import breproj_pkg::*;
(
    input  logic [LANE_W-1:0] cur,
    input  logic [LANE_W-1:0] above,
    input  logic [LANE_W-1:0] below,
    input  logic              left_nb,
    input  logic              right_nb,
    output logic [LANE_W-1:0] left_edges,
    output logic [LANE_W-1:0] right_edges,
    output logic [LANE_W-1:0] top_edges,
    output logic [LANE_W-1:0] bottom_edges
);

    logic [LANE_W-1:0] west;
    logic [LANE_W-1:0] east;

    // Neighbour pixels, with the bits from the adjoining lanes shifted in
    assign west = {cur[LANE_W-2:0], left_nb};
    assign east = {right_nb, cur[LANE_W-1:1]};

    assign left_edges   = cur & ~west;
    assign right_edges  = cur & ~east;
    assign top_edges    = cur & ~above;
    assign bottom_edges = cur & ~below;

endmodule

FILE: hdl/breproj_merge.sv
`timescale 1ns / 1ps

module breproj_merge
    import breproj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_ctrl_t         job,
    input  row_t              cur,
    input  lane_vec_t         left_lanes,
    input  lane_vec_t         right_lanes,
    input  lane_vec_t         top_lanes,
    input  lane_vec_t         bottom_lanes,
    output logic              adv,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;
    row_t             left_m;
    row_t             right_m;
    row_t             top_m;
    row_t             bottom_m;
    row_t             bound_m;

    // Join the lane slices back into full rows
    assign left_m   = row_t'(left_lanes);
    assign right_m  = row_t'(right_lanes);
    assign top_m    = row_t'(top_lanes);
    assign bottom_m = row_t'(bottom_lanes);
    assign bound_m  = left_m | right_m | top_m | bottom_m;

    assign adv = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (adv)
        begin
            m_tvalid_next = job.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && job.valid)
        begin
            m_tdata_reg <= {bound_m, bottom_m, top_m, right_m, left_m, cur};
            m_tlast_reg <= job.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
